### rtl/ksa_pkg.sv
// Shared types and constants for the keyed slot allocator.
// No dependencies; used by ksa_slot_store and keyed_slot_allocator.
`timescale 1ns / 1ps

package ksa_pkg;

   localparam int SLOT_COUNT_DEF = 128;
   localparam int ADDRESSABLE    = 128;
   localparam int SLOT_W         = 7;
   localparam int KEY_W          = 8;
   localparam int STATUS_W       = 3;

   localparam logic signed [KEY_W-1:0] FREE_KEY = -8'sd1;

   typedef enum logic [STATUS_W-1:0] {
      ST_FOUND     = 3'd0,
      ST_ALLOCATED = 3'd1,
      ST_FULL      = 3'd2,
      ST_INVALID   = 3'd3,
      ST_DEL_FAULT = 3'd4,
      ST_DELETED   = 3'd5
   } status_type;

   typedef enum logic {
      CMD_LOOKUP = 1'b0,
      CMD_DELETE = 1'b1
   } command_type;

   // request into the slot store; one address serves read, write and free
   typedef struct packed {
      logic                    rd_en;
      logic                    wr_en;
      logic                    clr_en;
      logic [SLOT_W-1:0]       addr;
      logic signed [KEY_W-1:0] key;
   } store_req_type;

   // registered read result
   typedef struct packed {
      logic                    occ;
      logic signed [KEY_W-1:0] key;
   } store_rsp_type;

endpackage

### rtl/ksa_slot_store.sv
// Slot store: key memory with one registered read port plus occupied flags.
// Depends on ksa_pkg for the request and response structs.
`timescale 1ns / 1ps

module ksa_slot_store #(
   parameter int DEPTH = ksa_pkg::SLOT_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ksa_pkg::store_req_type st_req,
   output ksa_pkg::store_rsp_type st_rsp
);

   localparam int IDX_W = $clog2(DEPTH);

   logic signed [ksa_pkg::KEY_W-1:0] key_mem [DEPTH];
   logic [DEPTH-1:0]                 occ_ff;
   logic [DEPTH-1:0]                 occ_in;
   logic signed [ksa_pkg::KEY_W-1:0] rd_key_ff;
   logic                             rd_occ_ff;
   logic [IDX_W-1:0]                 addr;

   assign addr = st_req.addr[IDX_W-1:0];

   always_comb begin
      occ_in = occ_ff;
      if (st_req.wr_en) begin
         occ_in[addr] = 1'b1;
      end
      if (st_req.clr_en) begin
         occ_in[addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (st_req.wr_en) begin
         key_mem[addr] <= st_req.key;
      end
      if (st_req.rd_en) begin
         rd_key_ff <= key_mem[addr];
         rd_occ_ff <= occ_ff[addr];
      end
   end

   assign st_rsp.occ = rd_occ_ff;
   assign st_rsp.key = rd_key_ff;

endmodule

### rtl/keyed_slot_allocator.sv
// Keyed slot allocator: sequencer, key comparator and result register.
// Usage:
//   req_* stream carries one command transaction: req_tuser is the command
//   (0 find or allocate, 1 delete), req_tdata holds the key and slot index.
//   rsp_* stream returns one transaction per command: status and slot.
// Operation:
//   Find or allocate walks up to min(SLOT_COUNT,128) slots one at a time,
//   each a registered memory read (S_RD) then one key compare (S_CHK); a
//   hit ends the walk early. Delete reads the slot, frees it in S_DEL if
//   occupied and reports from S_EMIT; an invalid key or out-of-range
//   delete goes straight to S_EMIT. The pace is set by the single read
//   port of the key memory and the one shared comparator. One command is
//   in flight at a time; req_tready is high only while idle.
// Reset:
//   Synchronous reset frees every slot at once (occupied flags cleared) and
//   empties the result register; the block is ready on the next cycle.
// Stall:
//   A result waits in the output register while rsp_tready is low; the
//   next command is taken meanwhile and its result held back until the
//   register empties.
`timescale 1ns / 1ps

module keyed_slot_allocator #(
   parameter int SLOT_COUNT = ksa_pkg::SLOT_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] order_key, [14:8] slot_index, [15] zero
   input  logic [0:0]  req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [2:0] status, [9:3] result_slot, [15:10] zero
);

   localparam int USABLE = (SLOT_COUNT < ksa_pkg::ADDRESSABLE) ?
                           SLOT_COUNT : ksa_pkg::ADDRESSABLE;
   localparam int IDX_W  = $clog2(USABLE);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(USABLE - 1);
   localparam logic [ksa_pkg::SLOT_W:0] USABLE_W = (ksa_pkg::SLOT_W + 1)'(USABLE);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD,
      S_CHK,
      S_DEL,
      S_EMIT
   } state_type;

   state_type                        state_ff, state_in;
   logic signed [ksa_pkg::KEY_W-1:0] key_ff, key_in;
   logic [ksa_pkg::SLOT_W-1:0]       idx_ff, idx_in;
   logic [IDX_W-1:0]                 ptr_ff, ptr_in;
   logic                             free_seen_ff, free_seen_in;
   logic [IDX_W-1:0]                 free_ptr_ff, free_ptr_in;
   ksa_pkg::status_type              status_ff, status_in;
   logic [ksa_pkg::SLOT_W-1:0]       slot_ff, slot_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   ksa_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic [ksa_pkg::SLOT_W-1:0]       rsp_slot_ff, rsp_slot_in;

   ksa_pkg::store_req_type st_req;
   ksa_pkg::store_rsp_type st_rsp;

   logic req_fire;
   logic key_hit;
   logic out_free;

   ksa_slot_store #(
      .DEPTH (USABLE)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .st_req (st_req),
      .st_rsp (st_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign key_hit    = st_rsp.occ && (st_rsp.key == key_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      ptr_in        = ptr_ff;
      free_seen_in  = free_seen_ff;
      free_ptr_in   = free_ptr_ff;
      status_in     = status_ff;
      slot_in       = slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      st_req        = '0;
      st_req.key    = key_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               key_in       = req_tdata[7:0];
               idx_in       = req_tdata[14:8];
               ptr_in       = '0;
               free_seen_in = 1'b0;
               slot_in      = '0;
               if (req_tuser[0] == ksa_pkg::CMD_DELETE) begin
                  if ({1'b0, req_tdata[14:8]} >= USABLE_W) begin
                     status_in = ksa_pkg::ST_DEL_FAULT;
                     state_in  = S_EMIT;
                  end else begin
                     st_req.rd_en = 1'b1;
                     st_req.addr  = req_tdata[14:8];
                     state_in     = S_DEL;
                  end
               end else if ($signed(req_tdata[7:0]) == ksa_pkg::FREE_KEY) begin
                  status_in = ksa_pkg::ST_INVALID;
                  state_in  = S_EMIT;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            st_req.rd_en = 1'b1;
            st_req.addr  = ksa_pkg::SLOT_W'(ptr_ff);
            state_in     = S_CHK;
         end
         S_CHK: begin
            if (key_hit) begin
               status_in = ksa_pkg::ST_FOUND;
               slot_in   = ksa_pkg::SLOT_W'(ptr_ff);
               state_in  = S_EMIT;
            end else begin
               if (!st_rsp.occ && !free_seen_ff) begin
                  free_seen_in = 1'b1;
                  free_ptr_in  = ptr_ff;
               end
               if (ptr_ff == LAST_IDX) begin
                  state_in = S_EMIT;
                  if (free_seen_ff || !st_rsp.occ) begin
                     st_req.wr_en = 1'b1;
                     st_req.addr  = ksa_pkg::SLOT_W'(free_seen_ff ? free_ptr_ff : ptr_ff);
                     status_in    = ksa_pkg::ST_ALLOCATED;
                     slot_in      = st_req.addr;
                  end else begin
                     status_in = ksa_pkg::ST_FULL;
                  end
               end else begin
                  ptr_in   = ptr_ff + 1'b1;
                  state_in = S_RD;
               end
            end
         end
         S_DEL: begin
            state_in = S_EMIT;
            if (st_rsp.occ) begin
               st_req.clr_en = 1'b1;
               st_req.addr   = idx_ff;
               status_in     = ksa_pkg::ST_DELETED;
               slot_in       = idx_ff;
            end else begin
               status_in = ksa_pkg::ST_DEL_FAULT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_slot_in   = slot_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         free_seen_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         free_seen_ff <= free_seen_in;
      end
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      ptr_ff        <= ptr_in;
      free_ptr_ff   <= free_ptr_in;
      status_ff     <= status_in;
      slot_ff       <= slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_slot_ff, rsp_status_ff};

   a_no_wr_and_clr : assert property (@(posedge clock) disable iff (reset)
      !(st_req.wr_en && st_req.clr_en))
      else $error("store write and free in the same cycle");

   a_alloc_into_free : assert property (@(posedge clock) disable iff (reset)
      st_req.wr_en |-> (free_seen_ff || !st_rsp.occ))
      else $error("allocation into an occupied slot");

   a_free_only_occupied : assert property (@(posedge clock) disable iff (reset)
      st_req.clr_en |-> st_rsp.occ)
      else $error("delete of a slot that is already free");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("ready again straight after a transaction");

   a_slot_zero_on_fail : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ksa_pkg::ST_FULL ||
                        rsp_status_ff == ksa_pkg::ST_INVALID ||
                        rsp_status_ff == ksa_pkg::ST_DEL_FAULT)) |-> (rsp_slot_ff == '0))
      else $error("non-zero slot on a failing status");

endmodule
